@@ hdl/mcw_pkg.sv @@
// Package: shared constants, item codes and the transfer structs of the covering-window block.
`default_nettype none

package mcw_pkg;

    // Default sizes
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int TEXT_DEPTH_DEF    = 4096;
    localparam int PATTERN_MAX_DEF   = 255;

    // Fixed field widths
    localparam int SYM_W        = 8;
    localparam int BEST_START_W = 12;
    localparam int BEST_LEN_W   = 13;

    // Pattern counts saturate at one byte
    localparam int         PC_W   = 8;
    localparam logic [7:0] PC_MAX = 8'd255;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_QUERY   = 2'd0,
        KIND_PATTERN = 2'd1,
        KIND_TEXT    = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SYM_W-1:0] symbol;
    } t_item;

    typedef struct packed {
        logic                    found;
        logic [BEST_START_W-1:0] best_start;
        logic [BEST_LEN_W-1:0]   best_length;
        logic                    overflow;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/mcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mcw_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/mcw_cnt_store.sv @@
// Count store: RAM plus per-entry valid bits so a clear is immediate; invalid entries read zero.
`default_nettype none

module mcw_cnt_store #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_clear,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [DEPTH-1:0]  r_valid;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [WIDTH-1:0]  ram_q;

    mcw_ram #(
        .WIDTH  (WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // Valid bits: cleared at once, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Track address of the data now on the RAM output
    always_ff @(posedge i_clk) begin
        r_rd_addr <= i_rd_addr;
    end

    assign o_rd_data = r_valid[r_rd_addr] ? ram_q : '0;

endmodule

`default_nettype wire

@@ hdl/minimum_covering_window_top.sv @@
// Top level: sequencer for the shortest covering window over a stored text stream.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------
//  item    | in        | start high, busy low     | i_item  (t_item)
//  result  | out       | o_done strobe, one cycle | o_result (t_result)
//
// A query, an unused kind or a dropped byte goes straight to S_RESP. A pattern byte
// passes S_P_UPD, a text byte S_T_UPD, then S_RESP if the window does not cover; else
// each left-end byte examined runs S_C_RDTXT, S_C_RDCNT and S_C_CHK (text read, count
// read, check, through the registered memories), then S_C_FIN does the length compare;
// the loop examines every dropped byte and the needed byte that stops it, if any.
// Reset (synchronous) and a new query clear the count stores at once by
// valid bits; the text store is not cleared and is only read where written.
// The receiver cannot stall: o_done marks the one cycle each result is valid.
`default_nettype none

module minimum_covering_window_top
    import mcw_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_item   i_item,
    output logic         busy,
    output logic         o_done,
    output t_result      o_result
);

    localparam int AW    = $clog2(ALPHABET_SIZE);
    localparam int TA_W  = $clog2(TEXT_DEPTH);
    localparam int POS_W = $clog2(TEXT_DEPTH + 1);
    localparam int WC_W  = POS_W;
    localparam int PL_W  = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W = (WC_W > PC_W) ? WC_W : PC_W;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_P_UPD   = 8'b0000_0010,
        S_T_UPD   = 8'b0000_0100,
        S_C_RDTXT = 8'b0000_1000,
        S_C_RDCNT = 8'b0001_0000,
        S_C_CHK   = 8'b0010_0000,
        S_C_FIN   = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_tpos, n_tpos;
    logic [TA_W-1:0]   r_ws, n_ws;
    logic [PL_W-1:0]   r_plen, n_plen;
    logic [PL_W-1:0]   r_matched, n_matched;
    logic [TA_W-1:0]   r_best_start, n_best_start;
    logic [POS_W-1:0]  r_best_len, n_best_len;
    logic              r_ovf, n_ovf;

    // Per-item payload registers
    logic [AW-1:0]     r_sym, n_sym;
    logic [AW-1:0]     r_first, n_first;
    logic [TA_W-1:0]   r_cur, n_cur;

    // Memory ports
    logic              clear;
    logic [AW-1:0]     cnt_rd_addr;
    logic              pc_wr_en;
    logic [PC_W-1:0]   pc_wr_data, pc_q;
    logic              wc_wr_en;
    logic [AW-1:0]     wc_wr_addr;
    logic [WC_W-1:0]   wc_wr_data, wc_q;
    logic              txt_wr_en;
    logic [SYM_W-1:0]  txt_q;

    logic              accept;
    logic              sym_ok;
    logic [WC_W-1:0]   wc_inc;
    logic [PL_W-1:0]   matched_inc;
    logic              count_needed;
    logic [POS_W-1:0]  win_len;

    assign accept = start && !busy;
    assign sym_ok = {1'b0, i_item.symbol} < (SYM_W + 1)'(ALPHABET_SIZE);

    mcw_cnt_store #(
        .WIDTH  (PC_W),
        .DEPTH  (ALPHABET_SIZE),
        .ADDR_W (AW)
    ) u_pat_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (clear),
        .i_rd_addr (cnt_rd_addr),
        .i_wr_en   (pc_wr_en),
        .i_wr_addr (r_sym),
        .i_wr_data (pc_wr_data),
        .o_rd_data (pc_q)
    );

    mcw_cnt_store #(
        .WIDTH  (WC_W),
        .DEPTH  (ALPHABET_SIZE),
        .ADDR_W (AW)
    ) u_win_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (clear),
        .i_rd_addr (cnt_rd_addr),
        .i_wr_en   (wc_wr_en),
        .i_wr_addr (wc_wr_addr),
        .i_wr_data (wc_wr_data),
        .o_rd_data (wc_q)
    );

    mcw_ram #(
        .WIDTH  (SYM_W),
        .DEPTH  (TEXT_DEPTH),
        .ADDR_W (TA_W)
    ) u_text (
        .i_clk     (i_clk),
        .i_wr_en   (txt_wr_en),
        .i_wr_addr (r_tpos[TA_W-1:0]),
        .i_wr_data (i_item.symbol),
        .i_rd_addr (r_ws),
        .o_rd_data (txt_q)
    );

    // Shared count arithmetic
    assign wc_inc       = wc_q + WC_W'(1);
    assign matched_inc  = r_matched + PL_W'(1);
    assign count_needed = (pc_q != '0) && (CMP_W'(wc_q) <= CMP_W'(pc_q));
    assign win_len      = POS_W'(r_cur) - POS_W'(r_ws) + POS_W'(1);

    // Count read address: item symbol at accept, first window byte in the loop
    always_comb begin
        cnt_rd_addr = i_item.symbol[AW-1:0];
        if (r_state == S_C_RDCNT) begin
            cnt_rd_addr = txt_q[AW-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_tpos       = r_tpos;
        n_ws         = r_ws;
        n_plen       = r_plen;
        n_matched    = r_matched;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_ovf        = r_ovf;
        n_sym        = r_sym;
        n_first      = r_first;
        n_cur        = r_cur;
        clear        = 1'b0;
        pc_wr_en     = 1'b0;
        pc_wr_data   = pc_q + PC_W'(1);
        wc_wr_en     = 1'b0;
        wc_wr_addr   = r_sym;
        wc_wr_data   = wc_inc;
        txt_wr_en    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESP;
                    n_sym   = i_item.symbol[AW-1:0];
                    n_cur   = r_tpos[TA_W-1:0];
                    case (i_item.kind)
                        KIND_QUERY: begin
                            clear        = 1'b1;
                            n_tpos       = '0;
                            n_ws         = '0;
                            n_plen       = '0;
                            n_matched    = '0;
                            n_best_start = '0;
                            n_best_len   = '0;
                            n_ovf        = 1'b0;
                        end
                        KIND_PATTERN: begin
                            if (sym_ok && r_tpos == '0) begin
                                if (r_plen >= PL_W'(PATTERN_MAX)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_state = S_P_UPD;
                                end
                            end
                        end
                        KIND_TEXT: begin
                            if (sym_ok) begin
                                if (r_tpos == POS_W'(TEXT_DEPTH)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    txt_wr_en = 1'b1;
                                    n_tpos    = r_tpos + POS_W'(1);
                                    n_state   = S_T_UPD;
                                end
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // Pattern histogram update
            S_P_UPD: begin
                n_state = S_RESP;
                if (pc_q >= PC_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    pc_wr_en = 1'b1;
                    n_plen   = r_plen + PL_W'(1);
                end
            end

            // Window grows on the right
            S_T_UPD: begin
                n_state  = S_RESP;
                wc_wr_en = 1'b1;
                if ((pc_q != '0) && (CMP_W'(wc_inc) <= CMP_W'(pc_q))) begin
                    n_matched = matched_inc;
                end
                if (r_plen != '0 && n_matched == r_plen) begin
                    n_state = (r_ws < r_cur) ? S_C_RDTXT : S_C_FIN;
                end
            end

            // Contract loop: text byte read is in flight
            S_C_RDTXT: begin
                n_state = S_C_RDCNT;
            end

            // Text byte out; count reads issued for it
            S_C_RDCNT: begin
                n_first = txt_q[AW-1:0];
                n_state = S_C_CHK;
            end

            // Drop the left byte unless it is still needed
            S_C_CHK: begin
                if (count_needed) begin
                    n_state = S_C_FIN;
                end else begin
                    wc_wr_en   = 1'b1;
                    wc_wr_addr = r_first;
                    wc_wr_data = wc_q - WC_W'(1);
                    n_ws       = r_ws + TA_W'(1);
                    n_state    = (n_ws < r_cur) ? S_C_RDTXT : S_C_FIN;
                end
            end

            // Keep the first shortest window
            S_C_FIN: begin
                n_state = S_RESP;
                if (r_best_len == '0 || win_len < r_best_len) begin
                    n_best_len   = win_len;
                    n_best_start = r_ws;
                end
            end

            S_RESP: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tpos       <= '0;
            r_ws         <= '0;
            r_plen       <= '0;
            r_matched    <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tpos       <= n_tpos;
            r_ws         <= n_ws;
            r_plen       <= n_plen;
            r_matched    <= n_matched;
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_ovf        <= n_ovf;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_first <= n_first;
        r_cur   <= n_cur;
    end

    // Result transfer
    assign busy                 = (r_state != S_IDLE);
    assign o_done               = (r_state == S_RESP);
    assign o_result.found       = (r_best_len != '0);
    assign o_result.best_start  = BEST_START_W'(r_best_start);
    assign o_result.best_length = BEST_LEN_W'(r_best_len);
    assign o_result.overflow    = r_ovf;

endmodule

`default_nettype wire
